// File: rtl/obb_obb_overlap_test_top_macros.svh
// Assertion helpers for the box overlap pipeline
`ifndef OBB_OBB_OVERLAP_TEST_TOP_MACROS_SVH
`define OBB_OBB_OVERLAP_TEST_TOP_MACROS_SVH

// implication in the same cycle, held off during reset
`define OBBO_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("obbo assertion failed");

// implication in the next cycle, held off during reset
`define OBBO_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("obbo assertion failed");

`endif

// File: rtl/obbo_pkg.sv
package obbo_pkg;

  localparam int unsigned RegW    = 63;
  localparam int unsigned MarginW = 20;
  localparam int unsigned AxisFrac = 19;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned NumSep  = 15;
  localparam int unsigned Latency = 7;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_A_CENTER  = 3'd0,
    CFG_A_HALF    = 3'd1,
    CFG_A_AXIS_X  = 3'd2,
    CFG_A_AXIS_Y  = 3'd3,
    CFG_A_AXIS_Z  = 3'd4,
    CFG_MARGIN    = 3'd5
  } cfg_idx_e;

endpackage

// File: rtl/obb_obb_overlap_test_top.sv
// Each start transaction leads to one done strobe after the last pipeline stage.
// Throughput: one box pair per cycle; busy_o stays low, a new pair may
// start every cycle. Set by the seven-stage multiply/sum pipeline.
// Reset: valid bits clear, box A registers clear, the margin register is 1.
// The receiver cannot stall; each result shows for one cycle on done_o.
module obb_obb_overlap_test_top #(
  parameter int unsigned COORD_BITS = 21
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [obbo_pkg::RegW-1:0]          b_center_i,
  input  logic [obbo_pkg::RegW-1:0]          b_half_size_i,
  input  logic [obbo_pkg::RegW-1:0]          b_axis_x_i,
  input  logic [obbo_pkg::RegW-1:0]          b_axis_y_i,
  input  logic [obbo_pkg::RegW-1:0]          b_axis_z_i,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [obbo_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [obbo_pkg::RegW-1:0]          cfg_data_i,
  output logic                               done_o,
  output logic                               overlap_o
);
  import obbo_pkg::*;

  localparam int C    = COORD_BITS;
  localparam int AF   = AxisFrac;
  localparam int RW   = 2*C + 2 - AF;                       // floored rotation term
  localparam int TW   = 2*C + 3 - AF;                       // translation in A frame
  localparam int ARW  = ((RW > MarginW) ? RW : MarginW) + 1; // |R| + margin, unsigned
  localparam int EW   = C + ARW + 1;                        // extent * AbsR
  localparam int TRW  = TW + RW;                            // t * R
  localparam int M1   = (EW > TRW) ? EW : TRW;
  localparam int M2   = (TW + AF + 1 > C + AF) ? TW + AF + 1 : C + AF;
  localparam int PW   = ((M1 > M2) ? M1 : M2) + 3;

  // configuration registers
  logic [RegW-1:0]    a_center_q, a_half_q, a_ax_q, a_ay_q, a_az_q;
  logic [MarginW-1:0] margin_q;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_center_q <= '0;
      a_half_q   <= '0;
      a_ax_q     <= '0;
      a_ay_q     <= '0;
      a_az_q     <= '0;
      margin_q   <= MarginW'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_A_CENTER: a_center_q <= cfg_data_i;
        CFG_A_HALF:   a_half_q   <= cfg_data_i;
        CFG_A_AXIS_X: a_ax_q     <= cfg_data_i;
        CFG_A_AXIS_Y: a_ay_q     <= cfg_data_i;
        CFG_A_AXIS_Z: a_az_q     <= cfg_data_i;
        CFG_MARGIN:   margin_q   <= cfg_data_i[MarginW-1:0];
        default: ;
      endcase
    end
  end

  logic [RegW-1:0] a_axes [3];
  assign a_axes[0] = a_ax_q;
  assign a_axes[1] = a_ay_q;
  assign a_axes[2] = a_az_q;

  logic accept;
  assign accept = start_i && !busy_o;

  // valid bits
  logic [Latency-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Latency-2:0], accept};
    end
  end

  // stage 1: unpack, center offset
  logic signed [C:0]   d1_q  [3];
  logic signed [C-1:0] eb1_q [3];
  logic signed [C-1:0] ub1_q [3][3];
  logic [RegW-1:0]     b_axes [3];
  assign b_axes[0] = b_axis_x_i;
  assign b_axes[1] = b_axis_y_i;
  assign b_axes[2] = b_axis_z_i;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      d1_q[k]  <= (C+1)'($signed(b_center_i[k*C +: C])) -
                  (C+1)'($signed(a_center_q[k*C +: C]));
      eb1_q[k] <= $signed(b_half_size_i[k*C +: C]);
      for (int j = 0; j < 3; j++) begin
        ub1_q[j][k] <= $signed(b_axes[j][k*C +: C]);
      end
    end
  end

  // stage 2: products of axis components
  logic signed [2*C-1:0] rp2_q [3][3][3];
  logic signed [2*C:0]   tp2_q [3][3];
  logic signed [C-1:0]   eb2_q [3];
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      eb2_q[i] <= eb1_q[i];
      for (int k = 0; k < 3; k++) begin
        tp2_q[i][k] <= d1_q[k] * $signed(a_axes[i][k*C +: C]);
        for (int j = 0; j < 3; j++) begin
          rp2_q[i][j][k] <= $signed(a_axes[i][k*C +: C]) * ub1_q[j][k];
        end
      end
    end
  end

  // stage 3: dot products, floor to axis fraction
  logic signed [RW-1:0] r3_q [3][3];
  logic signed [TW-1:0] t3_q [3];
  logic signed [C-1:0]  eb3_q [3];
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      eb3_q[i] <= eb2_q[i];
      t3_q[i]  <= TW'(((2*C+3)'(tp2_q[i][0]) + (2*C+3)'(tp2_q[i][1]) +
                       (2*C+3)'(tp2_q[i][2])) >>> AF);
      for (int j = 0; j < 3; j++) begin
        r3_q[i][j] <= RW'(((2*C+2)'(rp2_q[i][j][0]) + (2*C+2)'(rp2_q[i][j][1]) +
                           (2*C+2)'(rp2_q[i][j][2])) >>> AF);
      end
    end
  end

  // stage 4: AbsR
  logic signed [ARW:0]  ar4_q [3][3];
  logic signed [RW-1:0] r4_q  [3][3];
  logic signed [TW-1:0] t4_q  [3];
  logic signed [C-1:0]  eb4_q [3];
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      eb4_q[i] <= eb3_q[i];
      t4_q[i]  <= t3_q[i];
      for (int j = 0; j < 3; j++) begin
        r4_q[i][j]  <= r3_q[i][j];
        ar4_q[i][j] <= (r3_q[i][j] < 0) ?
                       (ARW+1)'(-(ARW+1)'(r3_q[i][j])) + (ARW+1)'(margin_q) :
                       (ARW+1)'(r3_q[i][j]) + (ARW+1)'(margin_q);
      end
    end
  end

  // stage 5: radius and projection products
  logic signed [EW-1:0]  eaar5_q [3][3][3];  // ea[m] * AR[n][j]
  logic signed [EW-1:0]  ebar5_q [3][3][3];  // eb[m] * AR[i][n], as [i][m][n]
  logic signed [TRW-1:0] tr5_q   [3][3][3];  // t[m] * R[n][j]
  logic signed [TW-1:0]  t5_q  [3];
  logic signed [C-1:0]   eb5_q [3];
  always_ff @(posedge clk_i) begin
    for (int m = 0; m < 3; m++) begin
      t5_q[m]  <= t4_q[m];
      eb5_q[m] <= eb4_q[m];
      for (int n = 0; n < 3; n++) begin
        for (int j = 0; j < 3; j++) begin
          eaar5_q[m][n][j] <= $signed(a_half_q[m*C +: C]) * ar4_q[n][j];
          ebar5_q[n][m][j] <= eb4_q[m] * ar4_q[n][j];
          tr5_q[m][n][j]   <= t4_q[m] * r4_q[n][j];
        end
      end
    end
  end

  // stage 6: separation tests
  logic signed [PW-1:0] ra, rb, p, ap;
  logic [NumSep-1:0]    sep_d, sep6_q;
  always_comb begin
    ra = '0; rb = '0; p = '0; ap = '0;
    sep_d = '0;
    for (int i = 0; i < 3; i++) begin
      ra = PW'($signed(a_half_q[i*C +: C])) <<< AF;
      rb = PW'(ebar5_q[i][0][0]) + PW'(ebar5_q[i][1][1]) + PW'(ebar5_q[i][2][2]);
      p  = PW'(t5_q[i]) <<< AF;
      ap = (p < 0) ? -p : p;
      sep_d[i] = ap > ra + rb;
    end
    for (int j = 0; j < 3; j++) begin
      ra = PW'(eaar5_q[0][0][j]) + PW'(eaar5_q[1][1][j]) + PW'(eaar5_q[2][2][j]);
      rb = PW'(eb5_q[j]) <<< AF;
      p  = PW'(tr5_q[0][0][j]) + PW'(tr5_q[1][1][j]) + PW'(tr5_q[2][2][j]);
      ap = (p < 0) ? -p : p;
      sep_d[3+j] = ap > ra + rb;
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        ra = PW'(eaar5_q[(i+1)%3][(i+2)%3][j]) + PW'(eaar5_q[(i+2)%3][(i+1)%3][j]);
        rb = PW'(ebar5_q[i][(j+1)%3][(j+2)%3]) + PW'(ebar5_q[i][(j+2)%3][(j+1)%3]);
        p  = PW'(tr5_q[(i+2)%3][(i+1)%3][j]) - PW'(tr5_q[(i+1)%3][(i+2)%3][j]);
        ap = (p < 0) ? -p : p;
        sep_d[6+3*i+j] = ap > ra + rb;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sep6_q <= sep_d;
  end

  // stage 7: result register
  logic overlap_q;
  always_ff @(posedge clk_i) begin
    overlap_q <= ~|sep6_q;
  end

  assign overlap_o = overlap_q;
  assign done_o    = vld_q[Latency-1];

`include "obb_obb_overlap_test_top_macros.svh"

  `OBBO_ASSERT_IMPL(a_done_has_start, clk_i, rst_ni, done_o, $past(vld_q[Latency-2]))
  `OBBO_ASSERT_NEXT(a_start_flows, clk_i, rst_ni, vld_q[0], vld_q[1])
  `OBBO_ASSERT_IMPL(a_never_busy, clk_i, rst_ni, start_i, !busy_o && cfg_ready_o)

endmodule
